@@ hw/rtl/assert_macros.svh @@
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, reset masks the check
`define AST_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("grid pair force check failed");

// implication checked in the next cycle
`define AST_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("grid pair force check failed");

`endif

@@ hw/rtl/gabpf_pkg.sv @@
// package: constants, types, fixed-point helpers and bump tables
`default_nettype none
package gabpf_pkg;
	localparam int FRAC_BITS = 16;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int MAX_POINTS_PER_LENGTH = 16;

	localparam int ROM_DEPTH = 1 << TABLE_ADDR_BITS;
	localparam int IDX_SH = 2 * FRAC_BITS - TABLE_ADDR_BITS;
	localparam int RND_SH = 32 - FRAC_BITS;
	localparam int CNT_W = (MAX_POINTS_PER_LENGTH > 1) ? $clog2(MAX_POINTS_PER_LENGTH) : 1;
	localparam int WIDE_W = 34 + $clog2(MAX_POINTS_PER_LENGTH + 1);
	localparam int ACC_W = 33 + 3 * $clog2(MAX_POINTS_PER_LENGTH + 1);
	localparam int SERIES_TERMS = 20;
	localparam longint unsigned EINV_Q32 = 64'd1580030169;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		REG_CUT_SQ = 3'd0,
		REG_INV_CUT_SQ = 3'd1,
		REG_NUC_WIDTH = 3'd2,
		REG_SUB_STEP = 3'd3,
		REG_PPL = 3'd4,
		REG_STRENGTH = 3'd5,
		REG_PHI_BAR = 3'd6,
		REG_CELL_VOLUME = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_GRID,
		OP_SUB,
		OP_FINAL
	} op_kind_t;

	typedef struct packed {
		logic [30:0] cut_sq;
		logic [30:0] inv_cut_sq;
		logic [30:0] nuc_width;
		logic [30:0] sub_step;
		logic [4:0] ppl;
		logic [30:0] strength;
		logic signed [31:0] phi_bar;
		logic [30:0] cell_volume;
	} cfg_t;

	typedef struct packed {
		logic vld;
		op_kind_t kind;
		logic [2:0][31:0] u;
		logic signed [31:0] fld;
	} op_t;

	typedef struct packed {
		logic vld;
		op_kind_t kind;
		logic inr;
		logic [2:0][31:0] u;
		logic signed [31:0] dphi;
		logic signed [31:0] d2;
		logic signed [31:0] cube3;
		logic signed [31:0] b;
		logic signed [31:0] d;
	} lk_t;

	typedef logic [31:0] rom_arr_t [ROM_DEPTH];

	// product in Q format, rounded half away from zero, saturated
	function automatic logic signed [31:0] qm(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		logic [63:0] m;
		logic neg;
		p = 64'(a) * 64'(b);
		neg = p[63];
		m = neg ? 64'(-p) : 64'(p);
		m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (!neg) begin
			if (m > 64'h7FFF_FFFF) return S32_MAX;
			return signed'(m[31:0]);
		end
		if (m >= 64'h8000_0000) return S32_MIN;
		return -signed'(m[31:0]);
	endfunction

	function automatic logic signed [31:0] sat_dbl(input logic signed [31:0] x);
		logic signed [32:0] t;
		t = {x, 1'b0};
		if (t > 33'sd2147483647) return S32_MAX;
		if (t < -33'sd2147483648) return S32_MIN;
		return t[31:0];
	endfunction

	function automatic logic signed [31:0] sat_neg(input logic signed [31:0] x);
		if (x == S32_MIN) return S32_MAX;
		return -x;
	endfunction

	function automatic logic signed [31:0] sat_wide(input logic signed [WIDE_W-1:0] x);
		if (x > WIDE_W'(S32_MAX)) return S32_MAX;
		if (x < WIDE_W'(S32_MIN)) return S32_MIN;
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] x);
		if (x > ACC_W'(S32_MAX)) return S32_MAX;
		if (x < ACC_W'(S32_MIN)) return S32_MIN;
		return x[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		return x[31] ? 32'(-x) : 32'(x);
	endfunction

	// quotient by shift and subtract, only used while the tables are built
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int bt = 63; bt >= 0; bt--) begin
			r = {r[62:0], num[bt]};
			if (r >= den) begin
				r = r - den;
				q[bt] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-x) for x in Q32, series on the fraction then powers of 1/e
	function automatic longint unsigned exp_neg_q32(input longint unsigned x);
		longint unsigned n;
		longint unsigned f;
		longint unsigned term;
		longint unsigned r;
		longint sum;
		n = x >> 32;
		f = x & 64'hFFFF_FFFF;
		term = 64'd1 << 32;
		sum = longint'(64'd1 << 32);
		if (n >= 48) return 64'd0;
		for (int i = 1; i <= SERIES_TERMS; i++) begin
			term = udiv64((term * f) >> 32, 64'(i));
			if ((i & 1) != 0) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		r = (sum < 0) ? 64'd0 : longint'(sum);
		for (longint unsigned j = 0; j < n; j++)
			r = (r * EINV_Q32 + (64'd1 << 31)) >> 32;
		return r;
	endfunction

	// bump table: entry k stands for s = k/N; B = exp(-k/(N-k)), D = B*N^2/(N-k)^2
	function automatic rom_arr_t build_rom(input logic want_d);
		rom_arr_t t;
		longint unsigned nn;
		longint unsigned rem;
		longint unsigned b32;
		longint unsigned d32;
		longint unsigned v;
		nn = 64'd1 << TABLE_ADDR_BITS;
		for (int k = 0; k < ROM_DEPTH; k++) begin
			rem = nn - longint'(k);
			b32 = exp_neg_q32(udiv64(longint'(k) << 32, rem));
			d32 = udiv64(b32 * nn * nn, rem * rem);
			v = want_d ? d32 : b32;
			t[k] = 32'((v + (64'd1 << (RND_SH - 1))) >> RND_SH);
		end
		return t;
	endfunction

	localparam rom_arr_t B_ROM = build_rom(1'b0);
	localparam rom_arr_t D_ROM = build_rom(1'b1);
endpackage
`default_nettype wire

@@ hw/rtl/grid_atom_bump_pair_force.sv @@
// top level: grid-point / atom bump potential pair force
// usage
//  - command channel: a pair transfer happens at a rising edge with start high and
//    busy low; sep_x/y/z and field_value are sampled at that edge
//  - config channel: cfg_valid with cfg_ready (always high) writes register cfg_index;
//    write only while no pair is outstanding
//  - results: done is high for exactly one cycle per pair with in_range,
//    chem_pot_add and force_add_x/y/z; the receiver cannot hold them off
// timing
//  - grid point only (points_per_length 0 or 1): one pair per cycle, busy stays low
//  - cube integration: busy is high while the sequencer walks the sub-points
//    through the one shared lookup pipeline, one a cycle, and then issues the
//    closing op; the result follows once that final op has run through the
//    pipeline
//  - the bump tables are constant, so no clearing pass is needed after reset
// reset
//  - arst_n clears the pipeline valids, the sequencer and the cube sums and
//    restores the register defaults
`default_nettype none
module grid_atom_bump_pair_force import gabpf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [31:0] sep_x,
	input wire logic [31:0] sep_y,
	input wire logic [31:0] sep_z,
	input wire logic [31:0] field_value,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	output logic done,
	output logic in_range,
	output logic [31:0] chem_pot_add,
	output logic [31:0] force_add_x,
	output logic [31:0] force_add_y,
	output logic [31:0] force_add_z
);
	cfg_t cfg;
	op_t op;
	lk_t lk;

	// register file
	gabpf_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
	);

	// one op a cycle: the pair itself, or the sub-points then the closing op
	gabpf_seq u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .sep_x(sep_x), .sep_y(sep_y),
		.sep_z(sep_z), .field_value(field_value), .cfg(cfg), .busy(busy), .op(op)
	);

	// stages 2 to 5: distance, range, index, table
	gabpf_lookup u_lookup (
		.clk(clk), .arst_n(arst_n), .op(op), .cfg(cfg), .lk(lk)
	);

	// stages 6 to 10: product chains and accumulation
	gabpf_force u_force (
		.clk(clk), .arst_n(arst_n), .lk(lk), .cfg(cfg), .done(done),
		.in_range(in_range), .chem_pot_add(chem_pot_add), .force_add_x(force_add_x),
		.force_add_y(force_add_y), .force_add_z(force_add_z)
	);
endmodule
`default_nettype wire

@@ hw/rtl/gabpf_cfg.sv @@
// configuration register file
`default_nettype none
module gabpf_cfg import gabpf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	output cfg_t cfg
);
	cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign cfg = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.cut_sq <= 31'd65536;
			regs_q.inv_cut_sq <= 31'd65536;
			regs_q.nuc_width <= 31'd65536;
			regs_q.sub_step <= 31'd65536;
			regs_q.ppl <= 5'd1;
			regs_q.strength <= 31'd65536;
			regs_q.phi_bar <= 32'sd6554;
			regs_q.cell_volume <= 31'd65536;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_CUT_SQ: regs_q.cut_sq <= cfg_data[30:0];
				REG_INV_CUT_SQ: regs_q.inv_cut_sq <= cfg_data[30:0];
				REG_NUC_WIDTH: regs_q.nuc_width <= cfg_data[30:0];
				REG_SUB_STEP: regs_q.sub_step <= cfg_data[30:0];
				REG_PPL: regs_q.ppl <= cfg_data[4:0];
				REG_STRENGTH: regs_q.strength <= cfg_data[30:0];
				REG_PHI_BAR: regs_q.phi_bar <= signed'(cfg_data);
				REG_CELL_VOLUME: regs_q.cell_volume <= cfg_data[30:0];
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/gabpf_seq.sv @@
// sequencer: issues the grid-point op or the sub-point sweep of a cube
`default_nettype none
module gabpf_seq import gabpf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [31:0] sep_x,
	input wire logic [31:0] sep_y,
	input wire logic [31:0] sep_z,
	input wire logic [31:0] field_value,
	input cfg_t cfg,
	output logic busy,
	output op_t op
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUB,
		ST_FINAL
	} state_t;

	state_t state_q;
	logic vld_s1;
	op_kind_t kind_s1;
	logic [2:0][31:0] u_s1;
	logic signed [31:0] fld_s1;
	logic [2:0][31:0] sep_q;
	logic signed [31:0] fld_q;
	logic signed [WIDE_W-1:0] org_q [3];
	logic signed [WIDE_W-1:0] w_q [3];
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] last_q;

	logic cube;
	logic [CNT_W-1:0] last_n;
	logic signed [WIDE_W-1:0] org_n [3];
	logic signed [WIDE_W-1:0] step;
	logic [2:0][31:0] sep_in;
	int ppl_i;

	always_comb begin
		ppl_i = (int'(cfg.ppl) > MAX_POINTS_PER_LENGTH) ? MAX_POINTS_PER_LENGTH : int'(cfg.ppl);
		cube = (ppl_i > 1);
		last_n = CNT_W'(ppl_i - 1);
		step = WIDE_W'(signed'({1'b0, cfg.sub_step}));
		sep_in = {sep_z, sep_y, sep_x};
		for (int c = 0; c < 3; c++)
			org_n[c] = WIDE_W'(signed'(sep_in[c])) - WIDE_W'(signed'({1'b0, cfg.nuc_width >> 1}));
	end

	assign busy = (state_q != ST_IDLE);
	assign op = '{vld: vld_s1, kind: kind_s1, u: u_s1, fld: fld_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1 <= 1'b0;
			kind_s1 <= OP_GRID;
			u_s1 <= '0;
			fld_s1 <= '0;
			sep_q <= '0;
			fld_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			last_q <= '0;
			for (int c = 0; c < 3; c++) begin
				org_q[c] <= '0;
				w_q[c] <= '0;
			end
		end else begin
			vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (cube) begin
							sep_q <= sep_in;
							fld_q <= signed'(field_value);
							for (int c = 0; c < 3; c++) begin
								org_q[c] <= org_n[c];
								w_q[c] <= org_n[c];
							end
							i_q <= '0;
							j_q <= '0;
							k_q <= '0;
							last_q <= last_n;
							state_q <= ST_SUB;
						end else begin
							vld_s1 <= 1'b1;
							kind_s1 <= OP_GRID;
							u_s1 <= sep_in;
							fld_s1 <= signed'(field_value);
						end
					end
				end
				ST_SUB: begin
					vld_s1 <= 1'b1;
					kind_s1 <= OP_SUB;
					fld_s1 <= fld_q;
					for (int c = 0; c < 3; c++)
						u_s1[c] <= sat_wide(w_q[c]);
					// z runs fastest, then y, then x
					if (k_q != last_q) begin
						k_q <= k_q + 1'b1;
						w_q[2] <= w_q[2] + step;
					end else begin
						k_q <= '0;
						w_q[2] <= org_q[2];
						if (j_q != last_q) begin
							j_q <= j_q + 1'b1;
							w_q[1] <= w_q[1] + step;
						end else begin
							j_q <= '0;
							w_q[1] <= org_q[1];
							if (i_q != last_q) begin
								i_q <= i_q + 1'b1;
								w_q[0] <= w_q[0] + step;
							end else begin
								state_q <= ST_FINAL;
							end
						end
					end
				end
				ST_FINAL: begin
					vld_s1 <= 1'b1;
					kind_s1 <= OP_FINAL;
					u_s1 <= sep_q;
					fld_s1 <= fld_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/gabpf_lookup.sv @@
// front pipeline: squared distance, range test, table index and table read
`default_nettype none
module gabpf_lookup import gabpf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input op_t op,
	input cfg_t cfg,
	output lk_t lk
);
	logic vld_s2, vld_s3, vld_s4, vld_s5;
	op_kind_t kind_s2, kind_s3, kind_s4, kind_s5;
	logic [2:0][31:0] u_s2, u_s3, u_s4, u_s5;
	logic signed [31:0] dphi_s2, dphi_s3, dphi_s4, dphi_s5;
	logic [63:0] sq_s2 [3];
	logic signed [31:0] ss_s2;
	logic inr_s3, inr_s4, inr_s5;
	logic [30:0] r2h_s3;
	logic signed [31:0] d2_s3, d2_s4, d2_s5;
	logic signed [31:0] cube3_s3, cube3_s4, cube3_s5;
	logic [TABLE_ADDR_BITS-1:0] idx_s4;
	logic [31:0] b_s5, d_s5;

	logic signed [32:0] dphi_w;
	logic signed [31:0] sub_s;
	logic [63:0] r2;
	logic [63:0] lim;
	logic [61:0] prod;
	logic [61:0] shifted;
	logic [TABLE_ADDR_BITS-1:0] idx_n;

	always_comb begin
		sub_s = signed'({1'b0, cfg.sub_step});
		dphi_w = 33'(op.fld) - 33'(cfg.phi_bar);
		r2 = sq_s2[0] + sq_s2[1] + sq_s2[2];
		lim = 64'(cfg.cut_sq) << FRAC_BITS;
		prod = 62'(r2h_s3) * 62'(cfg.inv_cut_sq);
		shifted = prod >> IDX_SH;
		idx_n = (shifted >= 62'(ROM_DEPTH)) ? TABLE_ADDR_BITS'(ROM_DEPTH - 1)
			: shifted[TABLE_ADDR_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s2 <= op.vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		// squares per axis, field offset, first sub-step product
		kind_s2 <= op.kind;
		u_s2 <= op.u;
		for (int c = 0; c < 3; c++)
			sq_s2[c] <= 64'(mag32(signed'(op.u[c]))) * 64'(mag32(signed'(op.u[c])));
		if (dphi_w > 33'sd2147483647) dphi_s2 <= S32_MAX;
		else if (dphi_w < -33'sd2147483648) dphi_s2 <= S32_MIN;
		else dphi_s2 <= dphi_w[31:0];
		ss_s2 <= qm(sub_s, sub_s);

		// range test, squared field offset, cube of the sub-step
		kind_s3 <= kind_s2;
		u_s3 <= u_s2;
		dphi_s3 <= dphi_s2;
		inr_s3 <= (r2 < lim);
		r2h_s3 <= r2[FRAC_BITS+30:FRAC_BITS];
		d2_s3 <= qm(dphi_s2, dphi_s2);
		cube3_s3 <= qm(ss_s2, sub_s);

		// table index
		kind_s4 <= kind_s3;
		u_s4 <= u_s3;
		dphi_s4 <= dphi_s3;
		inr_s4 <= inr_s3;
		d2_s4 <= d2_s3;
		cube3_s4 <= cube3_s3;
		idx_s4 <= idx_n;

		// table read
		kind_s5 <= kind_s4;
		u_s5 <= u_s4;
		dphi_s5 <= dphi_s4;
		inr_s5 <= inr_s4;
		d2_s5 <= d2_s4;
		cube3_s5 <= cube3_s4;
		b_s5 <= B_ROM[idx_s4];
		d_s5 <= D_ROM[idx_s4];
	end

	assign lk = '{vld: vld_s5, kind: kind_s5, inr: inr_s5, u: u_s5, dphi: dphi_s5,
		d2: d2_s5, cube3: cube3_s5, b: signed'(b_s5), d: signed'(d_s5)};
endmodule
`default_nettype wire

@@ hw/rtl/gabpf_force.sv @@
// back pipeline: product chains, cube accumulation and result registers
`default_nettype none
module gabpf_force import gabpf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input lk_t lk,
	input cfg_t cfg,
	output logic done,
	output logic in_range,
	output logic [31:0] chem_pot_add,
	output logic [31:0] force_add_x,
	output logic [31:0] force_add_y,
	output logic [31:0] force_add_z
);
	logic vld_s6, vld_s7, vld_s8, vld_s9;
	logic done_s10, in_range_s10;
	op_kind_t kind_s6, kind_s7, kind_s8, kind_s9;
	logic inr_s6, inr_s7, inr_s8, inr_s9;
	logic [2:0][31:0] u_s6, u_s7, u_s8, u_s9;
	logic signed [31:0] dphi_s6, d2_s6, d2_s7;
	logic signed [31:0] m1_s6, v_s6, m2_s7, cq_s7, m3_s8, chem_s8, chem_s9, g_s9;
	logic signed [31:0] t_s6 [3];
	logic signed [31:0] accs_s7 [3], accs_s8 [3], accs_s9 [3];
	logic signed [ACC_W-1:0] acc_q [3];
	logic signed [31:0] chem_s10;
	logic signed [31:0] f_s10 [3];

	logic signed [31:0] str_s, inv_s, cell_s;

	assign str_s = signed'({1'b0, cfg.strength});
	assign inv_s = signed'({1'b0, cfg.inv_cut_sq});
	assign cell_s = signed'({1'b0, cfg.cell_volume});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			done_s10 <= 1'b0;
			in_range_s10 <= 1'b0;
			for (int c = 0; c < 3; c++)
				acc_q[c] <= '0;
		end else begin
			vld_s6 <= lk.vld;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			done_s10 <= vld_s9 && (kind_s9 != OP_SUB);
			in_range_s10 <= vld_s9 && (kind_s9 != OP_SUB) && inr_s9;
			// in-range sub-points add in; any other op takes the sum and clears it
			if (vld_s6) begin
				for (int c = 0; c < 3; c++) begin
					if (kind_s6 == OP_SUB) begin
						if (inr_s6) acc_q[c] <= acc_q[c] + ACC_W'(t_s6[c]);
					end else begin
						acc_q[c] <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_s6 <= lk.kind;
		inr_s6 <= lk.inr;
		u_s6 <= lk.u;
		dphi_s6 <= lk.dphi;
		d2_s6 <= lk.d2;
		m1_s6 <= (lk.kind == OP_FINAL) ? qm(lk.cube3, lk.d2) : qm(lk.d, str_s);
		v_s6 <= qm(lk.b, str_s);
		for (int c = 0; c < 3; c++)
			t_s6[c] <= qm(lk.d, signed'(lk.u[c]));

		kind_s7 <= kind_s6;
		inr_s7 <= inr_s6;
		u_s7 <= u_s6;
		d2_s7 <= d2_s6;
		m2_s7 <= qm(m1_s6, inv_s);
		cq_s7 <= qm(dphi_s6, v_s6);
		for (int c = 0; c < 3; c++)
			accs_s7[c] <= sat_acc(acc_q[c]);

		kind_s8 <= kind_s7;
		inr_s8 <= inr_s7;
		u_s8 <= u_s7;
		m3_s8 <= (kind_s7 == OP_FINAL) ? qm(m2_s7, str_s) : qm(m2_s7, d2_s7);
		chem_s8 <= sat_dbl(cq_s7);
		accs_s8 <= accs_s7;

		kind_s9 <= kind_s8;
		inr_s9 <= inr_s8;
		u_s9 <= u_s8;
		chem_s9 <= chem_s8;
		g_s9 <= (kind_s8 == OP_FINAL) ? sat_dbl(m3_s8) : sat_dbl(qm(m3_s8, cell_s));
		accs_s9 <= accs_s8;

		chem_s10 <= inr_s9 ? chem_s9 : '0;
		for (int c = 0; c < 3; c++) begin
			if (!inr_s9) f_s10[c] <= '0;
			else if (kind_s9 == OP_FINAL) f_s10[c] <= sat_neg(qm(accs_s9[c], g_s9));
			else f_s10[c] <= sat_neg(qm(signed'(u_s9[c]), g_s9));
		end
	end

	assign done = done_s10;
	assign in_range = in_range_s10;
	assign chem_pot_add = chem_s10;
	assign force_add_x = f_s10[0];
	assign force_add_y = f_s10[1];
	assign force_add_z = f_s10[2];
endmodule
`default_nettype wire

@@ hw/rtl/gabpf_chk.sv @@
// port-level checker for the pair force block and its bind
`default_nettype none
`include "assert_macros.svh"
module gabpf_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic in_range,
	input wire logic [31:0] chem_pot_add,
	input wire logic [31:0] force_add_x,
	input wire logic [31:0] force_add_y,
	input wire logic [31:0] force_add_z
);
	// out of range results carry no increments
	`AST_IMP(a_zero_out, done && !in_range, chem_pot_add == 0 && force_add_x == 0 && force_add_y == 0 && force_add_z == 0)
	// range flag only with a result
	`AST_IMP(a_range_strobe, in_range, done)
	// a sweep only starts from a transfer
	`AST_IMP(a_busy_rise, $rose(busy), $past(start))
	// end of a sweep gives its result after the pipeline
	`AST_IMP(a_sweep_done, $fell(busy), ##9 done)
endmodule

bind grid_atom_bump_pair_force gabpf_chk u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.in_range(in_range), .chem_pot_add(chem_pot_add), .force_add_x(force_add_x),
	.force_add_y(force_add_y), .force_add_z(force_add_z)
);
`default_nettype wire

@@ dv/gabpf_checker.sv @@
// checker: watches the pair, config and result channels, predicts and compares
module gabpf_checker import gabpf_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic [31:0] sep_x,
	input wire logic [31:0] sep_y,
	input wire logic [31:0] sep_z,
	input wire logic [31:0] field_value,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic done,
	input wire logic in_range,
	input wire logic [31:0] chem_pot_add,
	input wire logic [31:0] force_add_x,
	input wire logic [31:0] force_add_y,
	input wire logic [31:0] force_add_z,
	output int errors,
	output int pending
);
	localparam int NN = 1 << TABLE_ADDR_BITS;

	typedef struct {
		logic inr;
		logic [31:0] chem;
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] fz;
	} pair_res_t;

	pair_res_t force_q[$];
	longint bump_b[NN];
	longint bump_d[NN];

	longint unsigned k_cut, k_inv, k_nw, k_step, k_ppl, k_str, k_vol;
	longint k_phib;

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fxmul(longint a, longint b);
		longint p;
		longint unsigned m;
		p = a * b;
		m = (p < 0) ? longint'(-p) : longint'(p);
		m = (m + 64'd32768) >> FRAC_BITS;
		return clip32((p < 0) ? -longint'(m) : longint'(m));
	endfunction

	function automatic longint unsigned decay_q32(longint unsigned x);
		longint unsigned whole, frac, tm, r;
		longint acc;
		whole = x >> 32;
		frac = x & 64'hFFFF_FFFF;
		tm = 64'd1 << 32;
		acc = 64'sd1 <<< 32;
		if (whole >= 48) return 0;
		for (int i = 1; i <= 20; i++) begin
			tm = ((tm * frac) >> 32) / longint'(i);
			if (i % 2 == 1) acc -= longint'(tm);
			else acc += longint'(tm);
		end
		r = (acc < 0) ? 0 : longint'(acc);
		for (longint unsigned j = 0; j < whole; j++)
			r = (r * 64'd1580030169 + (64'd1 << 31)) >> 32;
		return r;
	endfunction

	function automatic longint unsigned sqsum(longint a, longint b, longint c);
		longint unsigned x, y, z;
		x = (a < 0) ? -a : a;
		y = (b < 0) ? -b : b;
		z = (c < 0) ? -c : c;
		return x * x + y * y + z * z;
	endfunction

	function automatic int unsigned bump_slot(longint unsigned r2);
		longint unsigned ix;
		ix = ((r2 >> FRAC_BITS) * k_inv) >> (2 * FRAC_BITS - TABLE_ADDR_BITS);
		return (ix >= NN) ? NN - 1 : int'(ix);
	endfunction

	function automatic pair_res_t pair_force(logic [31:0] sx, logic [31:0] sy,
			logic [31:0] sz, logic [31:0] fv);
		pair_res_t res;
		longint s[3], dphi, d2, pot, g, p, acc[3], org[3], uvw[3], f[3];
		longint unsigned r2, lim, ppl, s2;
		int unsigned ix;
		s[0] = longint'(signed'(sx));
		s[1] = longint'(signed'(sy));
		s[2] = longint'(signed'(sz));
		r2 = sqsum(s[0], s[1], s[2]);
		lim = k_cut << FRAC_BITS;
		res = '{1'b0, '0, '0, '0, '0};
		if (!(r2 < lim)) return res;
		ix = bump_slot(r2);
		dphi = clip32(longint'(signed'(fv)) - k_phib);
		d2 = fxmul(dphi, dphi);
		pot = fxmul(bump_b[ix], longint'(k_str));
		res.inr = 1'b1;
		res.chem = 32'(clip32(2 * fxmul(dphi, pot)));
		ppl = (k_ppl > MAX_POINTS_PER_LENGTH) ? MAX_POINTS_PER_LENGTH : k_ppl;
		if (ppl <= 1) begin
			g = fxmul(fxmul(fxmul(fxmul(bump_d[ix], longint'(k_str)), longint'(k_inv)), d2),
				longint'(k_vol));
			g = clip32(2 * g);
			for (int c = 0; c < 3; c++) f[c] = clip32(-fxmul(s[c], g));
		end else begin
			// cube sum over sub-points inside the cutoff
			for (int c = 0; c < 3; c++) begin
				acc[c] = 0;
				org[c] = s[c] - longint'(k_nw >> 1);
			end
			for (longint i = 0; i < ppl; i++) begin
				uvw[0] = clip32(org[0] + i * longint'(k_step));
				for (longint j = 0; j < ppl; j++) begin
					uvw[1] = clip32(org[1] + j * longint'(k_step));
					for (longint k = 0; k < ppl; k++) begin
						uvw[2] = clip32(org[2] + k * longint'(k_step));
						s2 = sqsum(uvw[0], uvw[1], uvw[2]);
						if (s2 < lim) begin
							ix = bump_slot(s2);
							for (int c = 0; c < 3; c++) acc[c] += fxmul(bump_d[ix], uvw[c]);
						end
					end
				end
			end
			p = fxmul(fxmul(longint'(k_step), longint'(k_step)), longint'(k_step));
			p = fxmul(fxmul(fxmul(p, d2), longint'(k_inv)), longint'(k_str));
			p = clip32(2 * p);
			for (int c = 0; c < 3; c++) f[c] = clip32(-fxmul(clip32(acc[c]), p));
		end
		res.fx = 32'(f[0]);
		res.fy = 32'(f[1]);
		res.fz = 32'(f[2]);
		return res;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	// bump tables: entry k stands for s = k/N
	initial begin
		longint unsigned rem, b32, d32;
		errors = 0;
		for (int k = 0; k < NN; k++) begin
			rem = NN - k;
			b32 = decay_q32((longint'(k) << 32) / rem);
			d32 = b32 * NN * NN / (rem * rem);
			bump_b[k] = longint'((b32 + 64'd32768) >> 16);
			bump_d[k] = longint'((d32 + 64'd32768) >> 16);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		pair_res_t want;
		if (!arst_n) begin
			k_cut = 65536; k_inv = 65536; k_nw = 65536; k_step = 65536;
			k_ppl = 1; k_str = 65536; k_phib = 6554; k_vol = 65536;
			force_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_CUT_SQ: k_cut = cfg_data[30:0];
					REG_INV_CUT_SQ: k_inv = cfg_data[30:0];
					REG_NUC_WIDTH: k_nw = cfg_data[30:0];
					REG_SUB_STEP: k_step = cfg_data[30:0];
					REG_PPL: k_ppl = cfg_data[4:0];
					REG_STRENGTH: k_str = cfg_data[30:0];
					REG_PHI_BAR: k_phib = longint'(signed'(cfg_data));
					REG_CELL_VOLUME: k_vol = cfg_data[30:0];
					default: ;
				endcase
			end
			if (start && !busy)
				force_q.push_back(pair_force(sep_x, sep_y, sep_z, field_value));
			if (done) begin
				if (force_q.size() == 0) begin
					report("unexpected result", {31'd0, in_range}, 32'd0);
				end else begin
					want = force_q.pop_front();
					if (in_range !== want.inr) report("in_range", {31'd0, in_range}, {31'd0, want.inr});
					if (chem_pot_add !== want.chem) report("chem_pot_add", chem_pot_add, want.chem);
					if (force_add_x !== want.fx) report("force_add_x", force_add_x, want.fx);
					if (force_add_y !== want.fy) report("force_add_y", force_add_y, want.fy);
					if (force_add_z !== want.fz) report("force_add_z", force_add_z, want.fz);
				end
			end
		end
		pending = force_q.size();
	end
endmodule

@@ dv/tb_grid_atom_bump_pair_force.sv @@
// testbench top: pair stimulus, register phases and the final verdict
module tb_grid_atom_bump_pair_force;
	import gabpf_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic cfg_valid = 1'b0;
	logic [2:0] cfg_index = REG_CUT_SQ;
	logic [31:0] cfg_data = '0;
	logic [31:0] sep_x = '0, sep_y = '0, sep_z = '0, field_value = '0;
	logic busy, cfg_ready, done, in_range;
	logic [31:0] chem_pot_add, force_add_x, force_add_y, force_add_z;
	int errors, pending;

	// phase state: spread of the separations and the preferred field value
	int unsigned spread;
	logic [31:0] cur_phib;

	always #2 clk = ~clk;

	grid_atom_bump_pair_force u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sep_x(sep_x), .sep_y(sep_y), .sep_z(sep_z), .field_value(field_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .in_range(in_range),
		.chem_pot_add(chem_pot_add), .force_add_x(force_add_x),
		.force_add_y(force_add_y), .force_add_z(force_add_z)
	);

	gabpf_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sep_x(sep_x), .sep_y(sep_y), .sep_z(sep_z), .field_value(field_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .in_range(in_range),
		.chem_pot_add(chem_pot_add), .force_add_x(force_add_x),
		.force_add_y(force_add_y), .force_add_z(force_add_z),
		.errors(errors), .pending(pending)
	);

	// one pair transfer; entered and left at a falling edge, start left high
	task automatic send_pair(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] fv);
		sep_x = x; sep_y = y; sep_z = z; field_value = fv;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// one register transfer on the config channel
	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// drain: all results in, then a further wait that outlasts the pipeline
	task automatic drain();
		start = 1'b0;
		wait (pending == 0);
		repeat (24) @(posedge clk);
		@(negedge clk);
	endtask

	// mostly inside the cube around the atom, now and then anywhere at all
	function automatic logic [31:0] rand_sep();
		logic [31:0] v;
		if ($urandom_range(0, 7) == 0) return $urandom;
		v = $urandom_range(0, spread);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic logic [31:0] rand_field();
		if ($urandom_range(0, 3) == 0) return $urandom;
		return cur_phib + $urandom_range(0, 32'h40000) - 32'h20000;
	endfunction

	// program every register, then stream random pairs in bursts with gaps
	task automatic run_phase(logic [31:0] cut, logic [31:0] inv, logic [31:0] nw,
			logic [31:0] stp, logic [31:0] ppl, logic [31:0] str, logic [31:0] phib,
			logic [31:0] vol, int n, int unsigned w);
		int burst;
		drain();
		write_reg(REG_CUT_SQ, cut);
		write_reg(REG_INV_CUT_SQ, inv);
		write_reg(REG_NUC_WIDTH, nw);
		write_reg(REG_SUB_STEP, stp);
		write_reg(REG_PPL, ppl);
		write_reg(REG_STRENGTH, str);
		write_reg(REG_PHI_BAR, phib);
		write_reg(REG_CELL_VOLUME, vol);
		spread = w;
		cur_phib = phib;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				// gap between bursts; some stretches run back to back
				start = 1'b0;
				if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
				burst = $urandom_range(1, 14);
			end
			send_pair(rand_sep(), rand_sep(), rand_sep(), rand_field());
			burst--;
		end
		start = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed pairs at the register defaults (cutoff 1.0, grid point only)
		send_pair(32'd0, 32'd0, 32'd0, 32'd0);
		send_pair(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
		send_pair(32'd0, 32'd0, 32'd0, 32'h8000_0000);
		send_pair(32'h8000_0000, 32'd0, 32'd0, 32'd0);
		send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pair(32'd65536, 32'd0, 32'd0, 32'd100000);
		send_pair(32'd65535, 32'd0, 32'd0, 32'd100000);
		send_pair(-32'd65535, 32'd0, 32'd0, -32'd100000);
		send_pair(32'd0, -32'd46341, 32'd46340, 32'd6554);
		send_pair(32'd32768, -32'd32768, 32'd16384, 32'd123456);
		send_pair(32'd0, 32'd0, -32'd40000, -32'd65536);
		send_pair(32'd1, -32'd1, 32'd1, 32'h8000_0000);
		send_pair(32'hFFFF_FFFF, 32'd0, 32'd0, 32'h7FFF_FFFF);
		start = 1'b0;

		// zero points_per_length falls back to the grid point
		run_phase(32'd262144, 32'd16384, 32'd131072, 32'd131072, 32'd0,
			32'd196608, -32'd20000, 32'd8192, 250, 131072);
		// cutoff, width, step, strength and volume at their upper end, phi_bar at its lower end
		run_phase(32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 200, 32'h00B5_0000);
		// zero cutoff: nothing is ever in range
		run_phase(32'd0, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1,
			32'd1, 32'h7FFF_FFFF, 32'd1, 50, 65536);
		// cube integration at small sizes
		run_phase(32'd147456, 32'd29127, 32'd98304, 32'd49152, 32'd2,
			32'd131072, 32'd6554, 32'd65536, 300, 98304);
		run_phase(32'd65536, 32'd65536, 32'd65536, 32'd21845, 32'd3,
			32'd100000, 32'd0, 32'd32768, 200, 65536);
		run_phase(32'd589824, 32'd7282, 32'd196608, 32'd49152, 32'd4,
			32'd50000, 32'd30000, 32'd200000, 150, 196608);
		// largest cube, then a count above the maximum that must saturate
		run_phase(32'd65536, 32'd65536, 32'd65536, 32'd4096, 32'd16,
			32'd65536, 32'd6554, 32'd65536, 4, 65536);
		run_phase(32'd65536, 32'd65536, 32'd65536, 32'd4096, 32'd31,
			32'd65536, 32'd6554, 32'd65536, 3, 65536);
		// reciprocal that disagrees with the cutoff: index clamps
		run_phase(32'd65536, 32'h7FFF_FFFF, 32'd65536, 32'd65536, 32'd1,
			32'd655360, -32'd6554, 32'd65536, 150, 65536);
		// zero strength, phi_bar at its upper end
		run_phase(32'd262144, 32'd16384, 32'd131072, 32'd65536, 32'd1,
			32'd0, 32'h7FFF_FFFF, 32'd65536, 100, 131072);
		run_phase(32'd1048576, 32'd4096, 32'd262144, 32'd65536, 32'd1,
			32'd65536, 32'd6554, 32'd65536, 280, 262144);

		drain();
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#8000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/gabpf_pkg.sv
hw/rtl/gabpf_cfg.sv
hw/rtl/gabpf_seq.sv
hw/rtl/gabpf_lookup.sv
hw/rtl/gabpf_force.sv
hw/rtl/grid_atom_bump_pair_force.sv
hw/rtl/gabpf_chk.sv
dv/gabpf_checker.sv
dv/tb_grid_atom_bump_pair_force.sv
